/* rtl/core/crsc_pkg.sv */
// shared types, constants and crc function for the record slot checker
// no dependencies
`default_nettype none

package crsc_pkg;

   localparam int PAYLOAD_BYTES_DEF = 64;
   localparam int NEWEST_LEN_W      = 7;

   localparam logic [31:0] REC_MAGIC  = 32'h4346_4732;
   localparam logic [31:0] REC_COMMIT = 32'h5AA5_5AA5;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h1021;
   localparam logic [15:0] CRC_TOPBIT = 16'h8000;

   typedef enum logic [2:0] {
      KIND_MAGIC  = 3'd0,
      KIND_SEQ    = 3'd1,
      KIND_LEN    = 3'd2,
      KIND_PAY    = 3'd3,
      KIND_CRC    = 3'd4,
      KIND_COMMIT = 3'd5
   } kind_type;

   typedef struct packed {
      logic        slot;
      logic [31:0] data;
      kind_type    kind;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // crc-16/ccitt-false, one byte, msb first
   function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] v;
      v = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((v & CRC_TOPBIT) != 16'h0000) begin
            v = {v[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[14:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/config_record_slot_checker.sv */
// top level of the a/b record slot checker: front, word queue, back
// depends on crsc_pkg, crsc_front, crsc_queue, crsc_back
//
//  port group   dir  handshake            contents
//  req_         in   req_valid/req_stall  slot, record word
//  rsp_         out  rsp_valid/rsp_stall  verdict, newest slot summary, write target
//
// one word per cycle sustained unless a stall holds it; a taken word goes into the
// queue, and the back end registers the result of a commit word as it pops it
// the crc network folds up to four in-length bytes of a payload word per cycle
// synchronous reset clears position, crc, header checks, slot flags and queue
// a stalled result blocks only commit words; the two-entry queue absorbs the rest
`default_nettype none

module config_record_slot_checker #(
   parameter int PAYLOAD_BYTES = crsc_pkg::PAYLOAD_BYTES_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire                               req_slot,
   input  wire  [31:0]                       req_word_data,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic                              rsp_checked_slot,
   output logic                              rsp_slot_ok,
   output logic                              rsp_any_valid,
   output logic                              rsp_newest_slot,
   output logic [crsc_pkg::NEWEST_LEN_W-1:0] rsp_newest_length,
   output logic [31:0]                       rsp_newest_sequence,
   output logic                              rsp_write_target
);
   import crsc_pkg::*;

   queue_status_type q_stat;
   queue_entry_type  push_entry;
   queue_entry_type  head;
   logic             push;
   logic             pop;

   crsc_front #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_slot     (req_slot),
      .req_word_data(req_word_data),
      .q_stat       (q_stat),
      .push         (push),
      .push_entry   (push_entry)
   );

   crsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   crsc_back #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .q_stat             (q_stat),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_checked_slot   (rsp_checked_slot),
      .rsp_slot_ok        (rsp_slot_ok),
      .rsp_any_valid      (rsp_any_valid),
      .rsp_newest_slot    (rsp_newest_slot),
      .rsp_newest_length  (rsp_newest_length),
      .rsp_newest_sequence(rsp_newest_sequence),
      .rsp_write_target   (rsp_write_target)
   );

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue reports full and empty together");

   a_ok_implies_any: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slot_ok |-> rsp_any_valid)
      else $error("passing record but no valid slot reported");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_any_valid |->
         !rsp_newest_slot && rsp_newest_length == '0 && rsp_newest_sequence == 32'd0)
      else $error("newest fields not zero with no valid slot");

   a_commit_result: assert property (@(posedge clock) disable iff (reset)
      pop && head.kind == KIND_COMMIT |=> rsp_valid)
      else $error("commit word taken without a result");

endmodule

`default_nettype wire

/* rtl/core/crsc_front.sv */
// front end: accepts record words, counts position, tags each word's kind
// depends on crsc_pkg
`default_nettype none

module crsc_front #(
   parameter int PAYLOAD_BYTES = crsc_pkg::PAYLOAD_BYTES_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire                        req_slot,
   input  wire  [31:0]                req_word_data,
   input  crsc_pkg::queue_status_type q_stat,
   output logic                       push,
   output crsc_pkg::queue_entry_type  push_entry
);
   import crsc_pkg::*;

   localparam int PW       = (PAYLOAD_BYTES + 3) / 4;
   localparam int POS_CRC  = 3 + PW;
   localparam int POS_LAST = 4 + PW;
   localparam int POS_W    = $clog2(POS_LAST + 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   kind_type         kind;

   always_comb begin
      if (pos_ff == POS_W'(0)) begin
         kind = KIND_MAGIC;
      end else if (pos_ff == POS_W'(1)) begin
         kind = KIND_SEQ;
      end else if (pos_ff == POS_W'(2)) begin
         kind = KIND_LEN;
      end else if (pos_ff < POS_W'(POS_CRC)) begin
         kind = KIND_PAY;
      end else if (pos_ff == POS_W'(POS_CRC)) begin
         kind = KIND_CRC;
      end else begin
         kind = KIND_COMMIT;
      end
   end

   assign req_stall       = q_stat.full;
   assign push            = req_valid && !q_stat.full;
   assign push_entry.slot = req_slot;
   assign push_entry.data = req_word_data;
   assign push_entry.kind = kind;

   always_comb begin
      pos_in = pos_ff;
      if (push) begin
         pos_in = (kind == KIND_COMMIT) ? POS_W'(0) : POS_W'(pos_ff + POS_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/crsc_queue.sv */
// two-entry word queue between front and back
// depends on crsc_pkg
`default_nettype none

module crsc_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  crsc_pkg::queue_entry_type  push_entry,
   input  wire                        pop,
   output crsc_pkg::queue_entry_type  head,
   output crsc_pkg::queue_status_type q_stat
);
   import crsc_pkg::*;

   queue_entry_type entry_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;

   assign head         = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == 2'd2);
   assign q_stat.empty = (count_ff == 2'd0);

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign count_in  = 2'(count_ff + {1'b0, push} - {1'b0, pop});

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/crsc_back.sv */
// back end: crc, header checks, slot verdicts and the result register
// depends on crsc_pkg
`default_nettype none

module crsc_back #(
   parameter int PAYLOAD_BYTES = crsc_pkg::PAYLOAD_BYTES_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  crsc_pkg::queue_entry_type            head,
   input  crsc_pkg::queue_status_type           q_stat,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic                                 rsp_checked_slot,
   output logic                                 rsp_slot_ok,
   output logic                                 rsp_any_valid,
   output logic                                 rsp_newest_slot,
   output logic [crsc_pkg::NEWEST_LEN_W-1:0]    rsp_newest_length,
   output logic [31:0]                          rsp_newest_sequence,
   output logic                                 rsp_write_target
);
   import crsc_pkg::*;

   localparam int PW   = (PAYLOAD_BYTES + 3) / 4;
   localparam int BW   = $clog2(4 * PW);

   logic [15:0]             crc_ff, crc_in;
   logic [1:0]              hdr_ff, hdr_in;
   logic [31:0]             seq_ff;
   logic [15:0]             len_ff;
   logic [15:0]             scrc_ff;
   logic [BW-1:0]           base_ff, base_in;
   logic [1:0]              valid_ff, valid_in;
   logic [31:0]             sseq_ff [2];
   logic [31:0]             sseq_in [2];
   logic [NEWEST_LEN_W-1:0] slen_ff [2];
   logic [NEWEST_LEN_W-1:0] slen_in [2];

   logic        out_valid_ff, out_valid_in;
   logic        out_slot_ff, out_ok_ff, out_any_ff, out_newest_ff, out_target_ff;
   logic [NEWEST_LEN_W-1:0] out_len_ff;
   logic [31:0] out_seq_ff;

   logic        is_commit, take_commit;
   logic        ok, any, newest, target;
   logic [31:0] d_ab, d_ba;
   logic [15:0] crc_pay;
   logic [15:0] w_len;

   assign is_commit   = (head.kind == KIND_COMMIT);
   assign pop         = !q_stat.empty && (!is_commit || !out_valid_ff || !rsp_stall);
   assign take_commit = pop && is_commit;
   assign w_len       = head.data[31:16];

   // four byte steps, gated by the record length
   always_comb begin
      crc_pay = crc_ff;
      for (int b = 0; b < 4; b++) begin
         if (16'(16'(base_ff) + 16'(b)) < len_ff) begin
            crc_pay = crc16_byte(crc_pay, head.data[8*b +: 8]);
         end
      end
   end

   assign ok = (hdr_ff == 2'b11) && (head.data == REC_COMMIT) && (scrc_ff == crc_ff);

   always_comb begin
      valid_in = valid_ff;
      sseq_in  = sseq_ff;
      slen_in  = slen_ff;
      if (take_commit) begin
         valid_in[head.slot] = ok;
         sseq_in[head.slot]  = seq_ff;
         slen_in[head.slot]  = len_ff[NEWEST_LEN_W-1:0];
      end
   end

   // wrapping sequence compare on the updated slot table
   assign d_ab   = sseq_in[0] - sseq_in[1];
   assign d_ba   = sseq_in[1] - sseq_in[0];
   assign any    = valid_in[0] || valid_in[1];
   assign newest = !(!valid_in[1] || (valid_in[0] && d_ab != 32'd0 && !d_ab[31]));
   assign target = !(!valid_in[0] || (valid_in[1] && d_ba != 32'd0 && !d_ba[31]));

   always_comb begin
      crc_in  = crc_ff;
      hdr_in  = hdr_ff;
      base_in = base_ff;
      if (pop) begin
         case (head.kind)
            KIND_MAGIC: begin
               hdr_in = {1'b0, head.data == REC_MAGIC};
            end
            KIND_LEN: begin
               hdr_in[1] = (w_len != 16'd0) && (w_len <= 16'(PAYLOAD_BYTES));
               base_in   = '0;
            end
            KIND_PAY: begin
               crc_in  = crc_pay;
               base_in = BW'(base_ff + BW'(4));
            end
            KIND_COMMIT: begin
               crc_in = CRC_INIT;
               hdr_in = 2'b00;
            end
            default: begin
            end
         endcase
      end
   end

   assign out_valid_in = take_commit ? 1'b1 : (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         hdr_ff       <= 2'b00;
         base_ff      <= '0;
         valid_ff     <= 2'b00;
         out_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         hdr_ff       <= hdr_in;
         base_ff      <= base_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sseq_ff <= sseq_in;
      slen_ff <= slen_in;
      if (pop && head.kind == KIND_SEQ) begin
         seq_ff <= head.data;
      end
      if (pop && head.kind == KIND_LEN) begin
         len_ff <= w_len;
      end
      if (pop && head.kind == KIND_CRC) begin
         scrc_ff <= head.data[15:0];
      end
      if (take_commit) begin
         out_slot_ff   <= head.slot;
         out_ok_ff     <= ok;
         out_any_ff    <= any;
         out_newest_ff <= any ? newest : 1'b0;
         out_len_ff    <= any ? slen_in[newest] : '0;
         out_seq_ff    <= any ? sseq_in[newest] : 32'd0;
         out_target_ff <= target;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_checked_slot    = out_slot_ff;
   assign rsp_slot_ok         = out_ok_ff;
   assign rsp_any_valid       = out_any_ff;
   assign rsp_newest_slot     = out_newest_ff;
   assign rsp_newest_length   = out_len_ff;
   assign rsp_newest_sequence = out_seq_ff;
   assign rsp_write_target    = out_target_ff;

endmodule

`default_nettype wire
